// ----- src/ipac_pkg.sv -----
// Shared types, class codes and register indexes for the IP address classifier.
// No dependencies; imported by ipac_classify and the top level.
package ipac_pkg;

    localparam int unsigned ADDR_W   = 64;
    localparam int unsigned CLASS_W  = 4;
    localparam int unsigned TYPE_W   = 2;
    localparam int unsigned PREFIX_W = 8;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned IN_TDATA_W  = 128;
    localparam int unsigned OUT_TDATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_HIGH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LOW  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAMILY    = 8'd3;

    // special-range classes
    localparam logic [CLASS_W-1:0] CLS_NONE    = 4'd0;
    localparam logic [CLASS_W-1:0] CLS_PRIVATE = 4'd1;
    localparam logic [CLASS_W-1:0] CLS_BENCH   = 4'd2;
    localparam logic [CLASS_W-1:0] CLS_SHARED  = 4'd3;
    localparam logic [CLASS_W-1:0] CLS_DOC_V4  = 4'd4;
    localparam logic [CLASS_W-1:0] CLS_LINK_V4 = 4'd5;
    localparam logic [CLASS_W-1:0] CLS_DOC_V6  = 4'd6;
    localparam logic [CLASS_W-1:0] CLS_6TO4    = 4'd7;
    localparam logic [CLASS_W-1:0] CLS_ULA     = 4'd8;
    localparam logic [CLASS_W-1:0] CLS_TEREDO  = 4'd9;
    localparam logic [CLASS_W-1:0] CLS_ORCHID  = 4'd10;
    localparam logic [CLASS_W-1:0] CLS_AUTOCFG = 4'd11;
    localparam logic [CLASS_W-1:0] CLS_NAT64   = 4'd12;
    localparam logic [CLASS_W-1:0] CLS_SIIT    = 4'd13;

    // address types
    localparam logic [TYPE_W-1:0] ATYPE_NONE = 2'd0;
    localparam logic [TYPE_W-1:0] ATYPE_V4   = 2'd1;
    localparam logic [TYPE_W-1:0] ATYPE_V6   = 2'd2;

    typedef struct packed {
        logic                family_v6;
        logic [PREFIX_W-1:0] prefix_len;
        logic [ADDR_W-1:0]   base_low;
        logic [ADDR_W-1:0]   base_high;
    } t_subnet_cfg;

    // field order matches tdata, first field highest
    typedef struct packed {
        logic               in_subnet;
        logic [TYPE_W-1:0]  address_type;
        logic               routable;
        logic               address_valid;
        logic               multicast;
        logic               loopback;
        logic [CLASS_W-1:0] reservation_class;
    } t_result;

    function automatic logic nonroutable_class(input logic [CLASS_W-1:0] c);
        logic r;
        case (c) inside
            CLS_PRIVATE, CLS_BENCH, CLS_SHARED, CLS_DOC_V4, CLS_LINK_V4,
            CLS_DOC_V6, CLS_ULA, CLS_ORCHID, CLS_AUTOCFG: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/ip_address_classifier_subnet_match_core.sv -----
// Top level of the IP address classifier: stream ports, config registers, pipeline.
// Depends on ipac_pkg and ipac_classify.
//
// Usage:
//  - s_axis carries one address per request: tdata holds address_high (63:0) and
//    address_low (127:64); tuser is the family flag (1 = IPv6, IPv4 in low 32 bits).
//  - m_axis returns one result per request, in order, packed in a 16-bit tdata.
//  - The config channel writes the subnet base, prefix length and family by index
//    (0 base high, 1 base low, 2 prefix, 3 family); other indexes are dropped.
//    o_cfg_ready is always high; write only while no request is in flight.
//  - The pipeline is an input register, then the classify logic into the
//    result register. Throughput is one request per cycle while m_axis is ready,
//    with a single pass of compare and mask logic between those two registers.
//  - When m_axis stalls, the result register holds and the input register can
//    still take one more request; s_axis_tready drops only when both are full.
//  - Synchronous active-low reset empties the pipeline and clears the subnet
//    registers to zero, which disables the subnet match.
module ip_address_classifier_subnet_match_core
    import ipac_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // address_high, address_low
    input  logic                   s_axis_tuser,  // is_ipv6
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // reservation_class, loopback, multicast, address_valid, routable,
    // address_type, in_subnet, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_subnet_cfg           r_cfg;
    logic                  r_in_valid;
    logic [ADDR_W-1:0]     r_addr_high;
    logic [ADDR_W-1:0]     r_addr_low;
    logic                  r_is_ipv6;
    logic                  r_out_valid;
    t_result               r_result;
    t_result               n_result;
    logic                  out_free;
    logic                  advance;
    logic                  in_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BASE_HIGH: r_cfg.base_high  <= i_cfg_data;
                CFG_BASE_LOW:  r_cfg.base_low   <= i_cfg_data;
                CFG_PREFIX:    r_cfg.prefix_len <= i_cfg_data[PREFIX_W-1:0];
                CFG_FAMILY:    r_cfg.family_v6  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= in_take || (r_in_valid && !advance);
            r_out_valid <= advance || (r_out_valid && !m_axis_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_addr_high <= s_axis_tdata[63:0];
            r_addr_low  <= s_axis_tdata[127:64];
            r_is_ipv6   <= s_axis_tuser;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    ipac_classify u_classify (
        .i_addr_high (r_addr_high),
        .i_addr_low  (r_addr_low),
        .i_is_ipv6   (r_is_ipv6),
        .i_cfg       (r_cfg),
        .o_result    (n_result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, r_result};

    // a stalled result must not be lost or replaced
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_result))
        else $error("result changed while stalled");

    a_routable_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.routable |-> r_result.address_valid && !r_result.loopback)
        else $error("routable result on invalid or loopback address");

    a_type_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.routable == (r_result.address_type != ATYPE_NONE)))
        else $error("address type disagrees with routable flag");

    a_subnet_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.in_subnet |-> r_result.address_valid && !r_result.loopback)
        else $error("subnet match on invalid or loopback address");

endmodule

// ----- src/ipac_classify.sv -----
// Combinational classifier: special ranges, flags and subnet match for one address.
// Depends on ipac_pkg.
module ipac_classify
    import ipac_pkg::*;
(
    input  logic [ADDR_W-1:0] i_addr_high,
    input  logic [ADDR_W-1:0] i_addr_low,
    input  logic              i_is_ipv6,
    input  t_subnet_cfg       i_cfg,
    output t_result           o_result
);

    logic [31:0]        v4_addr;
    logic [7:0]         b0;
    logic [7:0]         b1;
    logic [7:0]         b2;
    logic [31:0]        top;
    logic [CLASS_W-1:0] cls_v4;
    logic [CLASS_W-1:0] cls_v6;
    logic               valid;
    logic               loop;
    logic               mcast;
    logic [CLASS_W-1:0] cls;
    logic               rout;
    logic [127:0]       mask_v6;
    logic [127:0]       addr_v6;
    logic [127:0]       base_v6;
    logic [31:0]        mask_v4;
    logic               match_v6;
    logic               match_v4;
    logic               match;

    assign v4_addr = i_addr_low[31:0];
    assign b0      = v4_addr[31:24];
    assign b1      = v4_addr[23:16];
    assign b2      = v4_addr[15:8];
    assign top     = i_addr_high[63:32];

    // later tests override earlier ones where ranges overlap
    always_comb begin
        cls_v4 = CLS_NONE;
        if (b0 == 8'd10 || (b0 == 8'd172 && b1 >= 8'd16 && b1 <= 8'd31) ||
            (b0 == 8'd192 && b1 == 8'd168)) begin
            cls_v4 = CLS_PRIVATE;
        end
        if (b0 == 8'd198 && (b1 == 8'd18 || b1 == 8'd19)) begin
            cls_v4 = CLS_BENCH;
        end
        if (b0 == 8'd100 && b1 >= 8'd64 && b1 <= 8'd127) begin
            cls_v4 = CLS_SHARED;
        end
        if ((b0 == 8'd192 && b1 == 8'd0 && b2 == 8'd2) ||
            (b0 == 8'd198 && b1 == 8'd51 && b2 == 8'd100) ||
            (b0 == 8'd203 && b1 == 8'd0 && b2 == 8'd113)) begin
            cls_v4 = CLS_DOC_V4;
        end
        if (b0 == 8'd169 && b1 == 8'd254) begin
            cls_v4 = CLS_LINK_V4;
        end
    end

    always_comb begin
        cls_v6 = CLS_NONE;
        if (top == 32'h2001_0DB8)             cls_v6 = CLS_DOC_V6;
        if (top[31:16] == 16'h2002)           cls_v6 = CLS_6TO4;
        if (top[31:25] == 7'b1111_110)        cls_v6 = CLS_ULA;
        if (top == 32'h2001_0000)             cls_v6 = CLS_TEREDO;
        if (top[31:4] == 28'h2001_001)        cls_v6 = CLS_ORCHID;
        if (top[31:16] == 16'hFE80)           cls_v6 = CLS_AUTOCFG;
        if (top == 32'h0064_FF9B)             cls_v6 = CLS_NAT64;
        if (i_addr_high == '0 && i_addr_low[63:32] == 32'hFFFF_0000) cls_v6 = CLS_SIIT;
    end

    always_comb begin
        if (i_is_ipv6) begin
            valid = (i_addr_high != '0) || (i_addr_low != '0);
            loop  = (i_addr_high == '0) && (i_addr_low == 64'd1);
            mcast = (i_addr_high[63:56] == 8'hFF);
            cls   = valid ? cls_v6 : CLS_NONE;
        end else begin
            valid = (v4_addr != '0);
            loop  = (b0 == 8'd127);
            mcast = (v4_addr[31:28] == 4'hE);
            cls   = valid ? cls_v4 : CLS_NONE;
        end
    end

    assign rout = valid && !loop && !nonroutable_class(cls);

    // masks only meaningful for prefix 1..128 (v6) or 1..32 (v4); others gated below
    assign mask_v6 = {128{1'b1}} << (8'd128 - i_cfg.prefix_len);
    assign mask_v4 = 32'hFFFF_FFFF << (6'd32 - i_cfg.prefix_len[5:0]);
    assign addr_v6 = {i_addr_high, i_addr_low};
    assign base_v6 = {i_cfg.base_high, i_cfg.base_low} & mask_v6;

    assign match_v6 = i_is_ipv6 && (i_cfg.prefix_len <= 8'd128) && (base_v6 != '0) &&
                      ((addr_v6 & mask_v6) == base_v6);
    assign match_v4 = !i_is_ipv6 && (i_cfg.prefix_len <= 8'd32) &&
                      ((i_cfg.base_low[31:0] & mask_v4) != '0) &&
                      ((v4_addr & mask_v4) == (i_cfg.base_low[31:0] & mask_v4));
    assign match = (i_cfg.prefix_len != '0) && (i_cfg.family_v6 ? match_v6 : match_v4);

    always_comb begin
        o_result.reservation_class = cls;
        o_result.loopback          = loop;
        o_result.multicast         = mcast;
        o_result.address_valid     = valid;
        o_result.routable          = rout;
        o_result.address_type      = rout ? (i_is_ipv6 ? ATYPE_V6 : ATYPE_V4) : ATYPE_NONE;
        o_result.in_subnet         = valid && !loop && match;
    end

endmodule

// ----- tb/sv/ip_address_classifier_subnet_match_core_tb.sv -----
// Testbench for ip_address_classifier_subnet_match_core: checks every result against a
// built-in predictor across subnet settings and idle patterns. Depends on ipac_pkg.
`timescale 1ns / 1ps

module ip_address_classifier_subnet_match_core_tb;
    import ipac_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PAST_END = CFG_FAMILY + 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP      = 8'hFF;
    localparam int unsigned RES_W = $bits(t_result);

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // address_high, address_low
    logic                   s_axis_tuser = 1'b0;  // is_ipv6
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // reservation_class, loopback, multicast, address_valid, routable,
    // address_type, in_subnet, zero fill
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // predictor's copy of the subnet registers
    logic [63:0] sub_base_hi = '0;
    logic [63:0] sub_base_lo = '0;
    logic [7:0]  sub_prefix = '0;
    logic        sub_v6 = 1'b0;

    t_result pending_results[$];
    int errors = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int sink_hold = 0;

    ip_address_classifier_subnet_match_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic logic blocks_routing(input logic [CLASS_W-1:0] c);
        case (c)
            CLS_PRIVATE, CLS_BENCH, CLS_SHARED, CLS_DOC_V4, CLS_LINK_V4,
            CLS_DOC_V6, CLS_ULA, CLS_ORCHID, CLS_AUTOCFG: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic subnet_hit(input logic v6, input logic [63:0] hi, lo);
        logic [127:0] m6;
        logic [31:0]  m4;
        int unsigned  p;
        p = sub_prefix;
        if (p == 0 || v6 != sub_v6) return 1'b0;
        if (sub_v6) begin
            if (p > 128) return 1'b0;
            m6 = ~({128{1'b1}} >> p);
            if (({sub_base_hi, sub_base_lo} & m6) == '0) return 1'b0;
            return ({hi, lo} & m6) == ({sub_base_hi, sub_base_lo} & m6);
        end
        if (p > 32) return 1'b0;
        m4 = ~({32{1'b1}} >> p);
        if ((sub_base_lo[31:0] & m4) == '0) return 1'b0;
        return (lo[31:0] & m4) == (sub_base_lo[31:0] & m4);
    endfunction

    function automatic t_result classify_addr(input logic [63:0] hi, lo, input logic v6);
        t_result            r;
        logic [31:0]        a, top;
        logic [7:0]         b0, b1, b2;
        logic [CLASS_W-1:0] cls;
        logic               valid, loop, rout;
        a   = lo[31:0];
        top = hi[63:32];
        b0  = a[31:24];
        b1  = a[23:16];
        b2  = a[15:8];
        cls = CLS_NONE;
        r   = '0;
        // later tests override earlier ones where ranges overlap
        if (v6) begin
            valid = (hi != '0) || (lo != '0);
            loop  = (hi == '0) && (lo == 64'd1);
            r.multicast = (hi[63:56] == 8'hFF);
            if (valid) begin
                if (top == 32'h20010DB8) cls = CLS_DOC_V6;
                if (top[31:16] == 16'h2002) cls = CLS_6TO4;
                if (top[31:25] == 7'b1111110) cls = CLS_ULA;
                if (top == 32'h20010000) cls = CLS_TEREDO;
                if (top[31:4] == 28'h2001001) cls = CLS_ORCHID;
                if (top[31:16] == 16'hFE80) cls = CLS_AUTOCFG;
                if (top == 32'h0064FF9B) cls = CLS_NAT64;
                if (hi == '0 && lo[63:32] == 32'hFFFF0000) cls = CLS_SIIT;
            end
        end else begin
            valid = (a != '0);
            loop  = (b0 == 8'd127);
            r.multicast = (a[31:28] == 4'hE);
            if (valid) begin
                if (b0 == 8'd10 || (b0 == 8'd172 && b1 >= 8'd16 && b1 <= 8'd31) ||
                    (b0 == 8'd192 && b1 == 8'd168))
                    cls = CLS_PRIVATE;
                if (b0 == 8'd198 && (b1 == 8'd18 || b1 == 8'd19)) cls = CLS_BENCH;
                if (b0 == 8'd100 && b1 >= 8'd64 && b1 <= 8'd127) cls = CLS_SHARED;
                if ((b0 == 8'd192 && b1 == 8'd0 && b2 == 8'd2) ||
                    (b0 == 8'd198 && b1 == 8'd51 && b2 == 8'd100) ||
                    (b0 == 8'd203 && b1 == 8'd0 && b2 == 8'd113))
                    cls = CLS_DOC_V4;
                if (b0 == 8'd169 && b1 == 8'd254) cls = CLS_LINK_V4;
            end
        end
        rout = valid && !loop && !blocks_routing(cls);
        r.reservation_class = cls;
        r.loopback          = loop;
        r.address_valid     = valid;
        r.routable          = rout;
        r.address_type      = !rout ? ATYPE_NONE : (v6 ? ATYPE_V6 : ATYPE_V4);
        r.in_subnet         = valid && !loop && subnet_hit(v6, hi, lo);
        return r;
    endfunction

    // ---------------- result side ----------------

    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic check_field(input string name, input longint unsigned want, got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[RES_W-1:0];
            if (pending_results.size() == 0) begin
                $error("result with no request pending: %h", m_axis_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("reservation_class", want.reservation_class,
                            got.reservation_class);
                check_field("loopback", want.loopback, got.loopback);
                check_field("multicast", want.multicast, got.multicast);
                check_field("address_valid", want.address_valid, got.address_valid);
                check_field("routable", want.routable, got.routable);
                check_field("address_type", want.address_type, got.address_type);
                check_field("in_subnet", want.in_subnet, got.in_subnet);
                check_field("tdata_fill", 0, m_axis_tdata[OUT_TDATA_W-1:RES_W]);
            end
        end
    end

    // ---------------- request side ----------------

    task automatic send_addr(input logic [63:0] hi, lo, input logic v6);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lo, hi};
        s_axis_tuser  <= v6;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(classify_addr(hi, lo, v6));
    endtask

    // drop valid and let every pending result drain
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_BASE_HIGH: sub_base_hi = val;
            CFG_BASE_LOW:  sub_base_lo = val;
            CFG_PREFIX:    sub_prefix  = val[7:0];
            CFG_FAMILY:    sub_v6      = val[0];
            default: ;
        endcase
    endtask

    // upper bits of prefix and family writes carry noise; an unused index is hit now and then
    task automatic set_subnet(input logic [63:0] hi, lo, input int unsigned p,
                              input logic fam);
        write_reg(CFG_BASE_HIGH, hi);
        write_reg(CFG_BASE_LOW, lo);
        write_reg(CFG_PREFIX, {$urandom, 24'($urandom_range(255)), p[7:0]});
        write_reg(CFG_FAMILY, {$urandom, 31'($urandom_range(32'h7FFFFFFF)), fam});
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(0, 1) ? CFG_IDX_TOP : CFG_IDX_PAST_END,
                      {$urandom, $urandom});
    endtask

    task automatic make_addr(output logic [63:0] hi, lo, output logic v6);
        logic [127:0] net, rnd, m, addr;
        int unsigned  pick, p;
        rnd  = {$urandom, $urandom, $urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 25) begin
            // aim at the configured subnet, sometimes from the other family
            v6  = ($urandom_range(9) == 0) ? !sub_v6 : sub_v6;
            net = {sub_base_hi, sub_base_lo};
            p   = sub_prefix;
            if (sub_v6)
                m = ~({128{1'b1}} >> ((p > 128) ? 128 : p));
            else
                m = {96'h0, ~({32{1'b1}} >> ((p > 32) ? 32 : p))};
        end else if (pick < 62) begin
            v6 = 1'b0;
            case ($urandom_range(12))
                0:  begin net = 128'h0A000000; p = 8;  end
                1:  begin net = 128'hAC100000; p = 12; end
                2:  begin net = 128'hC0A80000; p = 16; end
                3:  begin net = 128'hC6120000; p = 15; end
                4:  begin net = 128'h64400000; p = 10; end
                5:  begin net = 128'hC0000200; p = 24; end
                6:  begin net = 128'hC6336400; p = 24; end
                7:  begin net = 128'hCB007100; p = 24; end
                8:  begin net = 128'hA9FE0000; p = 16; end
                9:  begin net = 128'h7F000000; p = 8;  end
                10: begin net = 128'hE0000000; p = 4;  end
                11: begin net = 128'h0;         p = 32; end
                default: begin net = 128'h0;    p = 0;  end
            endcase
            m = {96'h0, ~({32{1'b1}} >> p)};
        end else begin
            v6 = 1'b1;
            case ($urandom_range(11))
                0:  begin net = {32'h20010DB8, 96'h0}; p = 32;  end
                1:  begin net = {32'h20020000, 96'h0}; p = 16;  end
                2:  begin net = {32'hFC000000, 96'h0}; p = 7;   end
                3:  begin net = {32'h20010000, 96'h0}; p = 32;  end
                4:  begin net = {32'h20010010, 96'h0}; p = 28;  end
                5:  begin net = {32'hFE800000, 96'h0}; p = 16;  end
                6:  begin net = {32'h0064FF9B, 96'h0}; p = 32;  end
                7:  begin net = {64'h0, 32'hFFFF0000, 32'h0}; p = 96; end
                8:  begin net = 128'h1; p = 128; end
                9:  begin net = 128'h0; p = 128; end
                10: begin net = {32'hFF000000, 96'h0}; p = 8;   end
                default: begin net = 128'h0; p = 0; end
            endcase
            m = ~({128{1'b1}} >> p);
        end
        addr = (net & m) | (rnd & ~m);
        // single bit flips probe range edges
        if ($urandom_range(4) == 0)
            addr = addr ^ (128'd1 << $urandom_range(127));
        hi = addr[127:64];
        lo = addr[63:0];
    endtask

    task automatic send_random(input int n);
        logic [63:0] hi, lo;
        logic        v6;
        repeat (n) begin
            make_addr(hi, lo, v6);
            send_addr(hi, lo, v6);
        end
    endtask

    task automatic load_random_subnet();
        logic        fam;
        int unsigned w, p;
        fam = 1'($urandom_range(1));
        w   = fam ? 128 : 32;
        case ($urandom_range(9))
            0: p = 0;
            1: p = 1;
            2: p = w;
            3: p = w + 1;
            4: p = 255;
            default: p = $urandom_range(w, 1);
        endcase
        if ($urandom_range(9) == 0)
            set_subnet('0, '0, p, fam);
        else
            set_subnet({$urandom, $urandom}, {$urandom, $urandom}, p, fam);
    endtask

    // ---------------- tests ----------------

    // every range and flag at reset settings, subnet match disabled
    task automatic test_ranges_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_addr('0, '0, 1'b0);
        send_addr('1, {32'hFFFFFFFF, 32'h0}, 1'b0);
        send_addr('0, 64'h0A000001, 1'b0);
        send_addr('0, 64'hAC100000, 1'b0);
        send_addr('0, 64'hAC0FFFFF, 1'b0);
        send_addr('0, 64'hAC1FFFFF, 1'b0);
        send_addr('0, 64'hC0A80101, 1'b0);
        send_addr('0, 64'hC6120001, 1'b0);
        send_addr('0, 64'h64400000, 1'b0);
        send_addr('0, 64'h647FFFFF, 1'b0);
        send_addr('0, 64'hC0000205, 1'b0);
        send_addr('0, 64'hC6336407, 1'b0);
        send_addr('0, 64'hCB007109, 1'b0);
        send_addr('0, 64'hA9FE0101, 1'b0);
        send_addr('0, 64'h7F000001, 1'b0);
        send_addr('0, 64'hEFFFFFFF, 1'b0);
        send_addr('0, '0, 1'b1);
        send_addr('0, 64'd1, 1'b1);
        send_addr(64'hFF02000000000000, 64'd1, 1'b1);
        send_addr(64'h20010DB800000000, 64'd1, 1'b1);
        send_addr(64'h2002000000000000, '0, 1'b1);
        send_addr(64'hFDFFFFFFFFFFFFFF, '1, 1'b1);
        send_addr(64'h2001000000000000, 64'd1, 1'b1);
        send_addr(64'h2001001F00000000, '0, 1'b1);
        send_addr(64'hFE80000000000000, 64'd1, 1'b1);
        send_addr(64'h0064FF9B00000000, 64'h01020304, 1'b1);
        send_addr('0, 64'hFFFF000001020304, 1'b1);
    endtask

    task automatic run_setting(input logic [63:0] hi, lo, input int unsigned p,
                               input logic fam);
        set_subnet(hi, lo, p, fam);
        send_random(16);
    endtask

    task automatic test_subnet_edges();
        src_idle_pct   = 30;
        sink_stall_pct = 30;
        run_setting({$urandom, $urandom}, {$urandom, 32'hC0A80A00}, 24, 1'b0);
        // unused indexes must leave the registers alone
        write_reg(CFG_IDX_PAST_END, '1);
        write_reg(CFG_IDX_TOP, {$urandom, $urandom});
        send_random(16);
        run_setting({$urandom, $urandom}, {$urandom, $urandom}, 32, 1'b0);
        run_setting('0, 64'h80000000, 1, 1'b0);
        run_setting({$urandom, $urandom}, {$urandom, $urandom}, 33, 1'b0);
        run_setting('0, 64'h00FFFFFF, 8, 1'b0);
        run_setting('1, '1, 32, 1'b0);
        run_setting('0, 64'h7F000000, 8, 1'b0);
        run_setting({$urandom, $urandom}, {$urandom, $urandom}, 128, 1'b1);
        run_setting({$urandom, $urandom}, {$urandom, $urandom}, 64, 1'b1);
        run_setting({$urandom, $urandom}, {$urandom, $urandom}, 65, 1'b1);
        run_setting(64'h8000000000000000, '0, 1, 1'b1);
        run_setting({$urandom, $urandom}, {$urandom, $urandom}, 129, 1'b1);
        run_setting({$urandom, $urandom}, {$urandom, $urandom}, 255, 1'b1);
        run_setting({$urandom, $urandom}, {$urandom, $urandom}, 0, 1'b1);
        run_setting(64'h000000000000FFFF, {$urandom, $urandom}, 40, 1'b1);
        run_setting('1, '1, 128, 1'b1);
        run_setting('0, 64'd1, 128, 1'b1);
    endtask

    task automatic test_random_traffic(input int src, input int sink);
        src_idle_pct   = src;
        sink_stall_pct = sink;
        repeat (4) begin
            load_random_subnet();
            send_random(75);
        end
    endtask

    // long receiver hold fills the pipe, then a full drain before more traffic
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        set_subnet({$urandom, $urandom}, {$urandom, $urandom}, 48, 1'b1);
        sink_hold = 300;
        send_random(40);
        wait_idle();
        send_random(20);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_ranges_directed();
        test_subnet_edges();
        test_random_traffic(0, 0);
        test_random_traffic(51, 0);
        test_random_traffic(0, 51);
        test_random_traffic(30, 30);
        test_backpressure();
        wait_idle();
        repeat (16) @(posedge i_clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
